// File: hw/rtl/piws_pkg.sv
// Shared types and constants of the projective inverse warp sampler.
// Sizes of the source store, arithmetic widths and pipeline stage indexes.
// No dependencies.
package piws_pkg;

    // Source store geometry (address is row * MAX_SRC_W + col)
    localparam int SRC_W_BITS = 10;
    localparam int SRC_H_BITS = 10;
    localparam int MAX_SRC_W  = 1 << SRC_W_BITS;
    localparam int MAX_SRC_H  = 1 << SRC_H_BITS;
    localparam int ADDR_W     = SRC_W_BITS + SRC_H_BITS;
    localparam int MEM_DEPTH  = MAX_SRC_W * MAX_SRC_H;
    localparam int MAX_OUT    = 4096;

    // Field widths
    localparam int COORD_W = 12;
    localparam int PIX_W   = 24;
    localparam int DIM_W   = 13;   // 2..4096
    localparam int SDIM_W  = 11;   // 1..1024

    // Arithmetic
    localparam int UQ_W       = 17;  // u, v in Q1.16
    localparam int UDIV_STEPS = UQ_W;
    localparam int ACC_W      = 51;  // row sums, signed
    localparam int Q_BITS     = SRC_W_BITS;
    localparam int DW         = ACC_W + Q_BITS;

    // Pipeline stage indexes
    localparam int ST_MUL = UDIV_STEPS;
    localparam int ST_SUM = ST_MUL + 1;
    localparam int ST_ABS = ST_SUM + 1;
    localparam int ST_CMP = ST_ABS + 1;
    localparam int ST_QD0 = ST_CMP + 1;
    localparam int ST_CHK = ST_QD0 + Q_BITS;
    localparam int NSTG   = ST_CHK + 1;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_MAP   = 1'b1
    } cmd_t;

    typedef enum logic [2:0] {
        REG_COEF_R0_AB  = 3'd0,
        REG_COEF_R0C_R1A = 3'd1,
        REG_COEF_R1_BC  = 3'd2,
        REG_COEF_R2_AB  = 3'd3,
        REG_COEF_R2_C   = 3'd4,
        REG_OUT_SIZE    = 3'd5,
        REG_SRC_SIZE    = 3'd6
    } reg_idx_t;

    // Request payload that travels alongside the arithmetic
    typedef struct packed {
        cmd_t               cmd;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pix;
        logic               miss;
        logic [COORD_W-1:0] drow;
    } side_t;

endpackage

// File: hw/rtl/projective_inverse_warp_sampler.sv
// Projective inverse warp sampler with nearest-pixel lookup, top level.
// Holds the register file, the warp pipeline and the source image store.
// Depends on piws_pkg.
//
// Usage: the input channel (in_valid / in_stall) carries requests. A write
// request (command 0) stores pixel_in at column coord_x, row coord_y of the
// 1024 x 1024 source store and yields no result. A map request (command 1)
// warps output pixel (coord_x, coord_y) through the 3x3 matrix and yields one
// result on the output channel (out_valid / out_stall): dest_col, dest_row,
// the sampled pixel and hit. Results keep request order.
// One request is taken per cycle while the output is not stalled. The depth
// comes from the 17-step u/v divider, the multiply and sum stages and the
// 10-step x/w, y/w divider ahead of the store read. When the receiver stalls
// a waiting result, the whole pipeline holds and in_stall rises the same
// cycle; nothing is lost or repeated. Reset empties the pipeline and loads
// the register defaults (identity h22, 4096 x 4096 output, 1024 x 1024
// source); the store content is undefined until written. The user must write
// the APB port only while the pipeline is empty; the block does not check.
module projective_inverse_warp_sampler
    import piws_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // APB configuration
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [5:0]           paddr,
    input  logic [63:0]          pwdata,
    output logic [63:0]          prdata,
    output logic                 pready,
    // request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 command,
    input  logic [COORD_W-1:0]   coord_x,
    input  logic [COORD_W-1:0]   coord_y,
    input  logic [PIX_W-1:0]     pixel_in,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [COORD_W-1:0]   dest_col,
    output logic [COORD_W-1:0]   dest_row,
    output logic [PIX_W-1:0]     pixel_out,
    output logic                 hit
);

    // ------------------------------------------------------------------
    // Register file
    // ------------------------------------------------------------------
    logic [63:0] coef0_reg, coef1_reg, coef2_reg, coef3_reg;
    logic [31:0] coef4_reg;
    logic [28:0] out_size_reg;
    logic [26:0] src_size_reg;
    logic        cfg_wr;
    reg_idx_t    cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = reg_idx_t'(paddr[5:3]);

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef0_reg    <= '0;
            coef1_reg    <= '0;
            coef2_reg    <= '0;
            coef3_reg    <= '0;
            coef4_reg    <= 32'h0001_0000;
            out_size_reg <= 29'h1000_1000;
            src_size_reg <= 27'h0400_0400;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_COEF_R0_AB:   coef0_reg    <= pwdata;
                REG_COEF_R0C_R1A: coef1_reg    <= pwdata;
                REG_COEF_R1_BC:   coef2_reg    <= pwdata;
                REG_COEF_R2_AB:   coef3_reg    <= pwdata;
                REG_COEF_R2_C:    coef4_reg    <= pwdata[31:0];
                REG_OUT_SIZE:     out_size_reg <= pwdata[28:0];
                REG_SRC_SIZE:     src_size_reg <= pwdata[26:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (cfg_idx)
            REG_COEF_R0_AB:   prdata = coef0_reg;
            REG_COEF_R0C_R1A: prdata = coef1_reg;
            REG_COEF_R1_BC:   prdata = coef2_reg;
            REG_COEF_R2_AB:   prdata = coef3_reg;
            REG_COEF_R2_C:    prdata = {32'd0, coef4_reg};
            REG_OUT_SIZE:     prdata = {35'd0, out_size_reg};
            REG_SRC_SIZE:     prdata = {37'd0, src_size_reg};
            default:          prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Decoded configuration (static while requests are in flight)
    // ------------------------------------------------------------------
    logic [DIM_W-1:0]   ow, oh;
    logic [SDIM_W-1:0]  sw, sh;
    logic [COORD_W-1:0] du, dv;
    logic signed [31:0] h00, h01, h02, h10, h11, h12, h20, h21, h22;

    // Saturate the size fields
    always_comb
    begin
        if (out_size_reg[15:0] < 16'd2)
            ow = DIM_W'(2);
        else if (out_size_reg[15:0] > 16'(MAX_OUT))
            ow = DIM_W'(MAX_OUT);
        else
            ow = out_size_reg[DIM_W-1:0];

        if (out_size_reg[28:16] < 13'd2)
            oh = DIM_W'(2);
        else if (out_size_reg[28:16] > 13'(MAX_OUT))
            oh = DIM_W'(MAX_OUT);
        else
            oh = out_size_reg[28:16];

        if (src_size_reg[15:0] < 16'd1)
            sw = SDIM_W'(1);
        else if (src_size_reg[15:0] > 16'(MAX_SRC_W))
            sw = SDIM_W'(MAX_SRC_W);
        else
            sw = src_size_reg[SDIM_W-1:0];

        if (src_size_reg[26:16] < 11'd1)
            sh = SDIM_W'(1);
        else if (src_size_reg[26:16] > 11'(MAX_SRC_H))
            sh = SDIM_W'(MAX_SRC_H);
        else
            sh = src_size_reg[26:16];
    end

    assign du  = COORD_W'(ow - DIM_W'(1));
    assign dv  = COORD_W'(oh - DIM_W'(1));
    assign h00 = $signed(coef0_reg[31:0]);
    assign h01 = $signed(coef0_reg[63:32]);
    assign h02 = $signed(coef1_reg[31:0]);
    assign h10 = $signed(coef1_reg[63:32]);
    assign h11 = $signed(coef2_reg[31:0]);
    assign h12 = $signed(coef2_reg[63:32]);
    assign h20 = $signed(coef3_reg[31:0]);
    assign h21 = $signed(coef3_reg[63:32]);
    assign h22 = $signed(coef4_reg);

    // ------------------------------------------------------------------
    // Pipeline control: one global advance, valid bits per stage
    // ------------------------------------------------------------------
    logic  adv;
    logic  out_valid_reg;
    logic  vld_reg [NSTG];
    side_t side_reg [NSTG];

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NSTG; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NSTG; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    // Entry payload
    side_t side_in;

    always_comb
    begin
        side_in.cmd  = cmd_t'(command);
        side_in.col  = coord_x;
        side_in.row  = coord_y;
        side_in.pix  = pixel_in;
        side_in.miss = !(({1'b0, coord_x} < ow) && ({1'b0, coord_y} < oh));
        side_in.drow = COORD_W'(oh - DIM_W'(1) - {1'b0, coord_y});
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= side_in;
            for (int k = 1; k < NSTG; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // u = j*65536/(W-1), v = i*65536/(H-1): one quotient bit per stage
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] u_rem_reg [UDIV_STEPS];
    logic [COORD_W-1:0] v_rem_reg [UDIV_STEPS];
    logic [UQ_W-1:0]    u_q_reg   [UDIV_STEPS];
    logic [UQ_W-1:0]    v_q_reg   [UDIV_STEPS];
    logic [COORD_W:0]   u_sh      [UDIV_STEPS];
    logic [COORD_W:0]   v_sh      [UDIV_STEPS];
    logic               u_ge      [UDIV_STEPS];
    logic               v_ge      [UDIV_STEPS];

    // Trial subtract of each step
    always_comb
    begin
        u_sh[0] = {1'b0, coord_x};
        v_sh[0] = {1'b0, coord_y};
        for (int k = 1; k < UDIV_STEPS; k++)
        begin
            u_sh[k] = {u_rem_reg[k-1], 1'b0};
            v_sh[k] = {v_rem_reg[k-1], 1'b0};
        end
        for (int k = 0; k < UDIV_STEPS; k++)
        begin
            u_ge[k] = u_sh[k] >= {1'b0, du};
            v_ge[k] = v_sh[k] >= {1'b0, dv};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_rem_reg[0] <= u_ge[0] ? COORD_W'(u_sh[0] - {1'b0, du}) : u_sh[0][COORD_W-1:0];
            v_rem_reg[0] <= v_ge[0] ? COORD_W'(v_sh[0] - {1'b0, dv}) : v_sh[0][COORD_W-1:0];
            u_q_reg[0]   <= UQ_W'(u_ge[0]);
            v_q_reg[0]   <= UQ_W'(v_ge[0]);
            for (int k = 1; k < UDIV_STEPS; k++)
            begin
                u_rem_reg[k] <= u_ge[k] ? COORD_W'(u_sh[k] - {1'b0, du})
                                        : u_sh[k][COORD_W-1:0];
                v_rem_reg[k] <= v_ge[k] ? COORD_W'(v_sh[k] - {1'b0, dv})
                                        : v_sh[k][COORD_W-1:0];
                u_q_reg[k]   <= {u_q_reg[k-1][UQ_W-2:0], u_ge[k]};
                v_q_reg[k]   <= {v_q_reg[k-1][UQ_W-2:0], v_ge[k]};
            end
        end
    end

    // ------------------------------------------------------------------
    // Matrix products, then row sums
    // ------------------------------------------------------------------
    logic signed [UQ_W:0]    u_s, v_s;
    logic signed [ACC_W-1:0] mx0_reg, mx1_reg, my0_reg, my1_reg, mw0_reg, mw1_reg;
    logic signed [ACC_W-1:0] xs_reg, ys_reg, ws_reg;

    assign u_s = $signed({1'b0, u_q_reg[UDIV_STEPS-1]});
    assign v_s = $signed({1'b0, v_q_reg[UDIV_STEPS-1]});

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mx0_reg <= ACC_W'(h00 * u_s);
            mx1_reg <= ACC_W'(h01 * v_s);
            my0_reg <= ACC_W'(h10 * u_s);
            my1_reg <= ACC_W'(h11 * v_s);
            mw0_reg <= ACC_W'(h20 * u_s);
            mw1_reg <= ACC_W'(h21 * v_s);

            xs_reg <= mx0_reg + mx1_reg + (ACC_W'(h02) <<< 16);
            ys_reg <= my0_reg + my1_reg + (ACC_W'(h12) <<< 16);
            ws_reg <= mw0_reg + mw1_reg + (ACC_W'(h22) <<< 16);
        end
    end

    // ------------------------------------------------------------------
    // Magnitudes and signs, then range precheck against 1024 * |w|
    // ------------------------------------------------------------------
    logic [ACC_W-1:0] ax_reg, ay_reg, aw_reg;
    logic             sgx_reg, sgy_reg, sgw_reg, wz_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg  <= xs_reg[ACC_W-1] ? ACC_W'(-xs_reg) : xs_reg;
            ay_reg  <= ys_reg[ACC_W-1] ? ACC_W'(-ys_reg) : ys_reg;
            aw_reg  <= ws_reg[ACC_W-1] ? ACC_W'(-ws_reg) : ws_reg;
            sgx_reg <= xs_reg[ACC_W-1];
            sgy_reg <= ys_reg[ACC_W-1];
            sgw_reg <= ws_reg[ACC_W-1];
            wz_reg  <= (ws_reg == '0);
        end
    end

    // Divider lanes: index 0 is the precheck stage, 1..Q_BITS the steps
    logic [DW-1:0]     rx_reg  [Q_BITS+1];
    logic [DW-1:0]     ry_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] qx_reg  [Q_BITS+1];
    logic [Q_BITS-1:0] qy_reg  [Q_BITS+1];
    logic [ACC_W-1:0]  dw_reg  [Q_BITS+1];
    logic              ovx_reg [Q_BITS+1];
    logic              ovy_reg [Q_BITS+1];
    logic              okx_reg [Q_BITS+1];
    logic              oky_reg [Q_BITS+1];
    logic              wzq_reg [Q_BITS+1];
    logic [DW-1:0]     dtst    [Q_BITS];
    logic              x_ge    [Q_BITS];
    logic              y_ge    [Q_BITS];

    // Trial subtract of aligned divisor
    always_comb
    begin
        for (int t = 0; t < Q_BITS; t++)
        begin
            dtst[t] = DW'(dw_reg[t]) << (Q_BITS - 1 - t);
            x_ge[t] = rx_reg[t] >= dtst[t];
            y_ge[t] = ry_reg[t] >= dtst[t];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rx_reg[0]  <= DW'(ax_reg);
            ry_reg[0]  <= DW'(ay_reg);
            qx_reg[0]  <= '0;
            qy_reg[0]  <= '0;
            dw_reg[0]  <= aw_reg;
            ovx_reg[0] <= DW'(ax_reg) >= (DW'(aw_reg) << Q_BITS);
            ovy_reg[0] <= DW'(ay_reg) >= (DW'(aw_reg) << Q_BITS);
            okx_reg[0] <= (sgx_reg == sgw_reg);
            oky_reg[0] <= (sgy_reg == sgw_reg);
            wzq_reg[0] <= wz_reg;
            for (int t = 0; t < Q_BITS; t++)
            begin
                rx_reg[t+1]  <= x_ge[t] ? rx_reg[t] - dtst[t] : rx_reg[t];
                ry_reg[t+1]  <= y_ge[t] ? ry_reg[t] - dtst[t] : ry_reg[t];
                qx_reg[t+1]  <= {qx_reg[t][Q_BITS-2:0], x_ge[t]};
                qy_reg[t+1]  <= {qy_reg[t][Q_BITS-2:0], y_ge[t]};
                dw_reg[t+1]  <= dw_reg[t];
                ovx_reg[t+1] <= ovx_reg[t];
                ovy_reg[t+1] <= ovy_reg[t];
                okx_reg[t+1] <= okx_reg[t];
                oky_reg[t+1] <= oky_reg[t];
                wzq_reg[t+1] <= wzq_reg[t];
            end
        end
    end

    // ------------------------------------------------------------------
    // Bounds check and store address
    // ------------------------------------------------------------------
    side_t             sq;
    logic [Q_BITS-1:0] qx, qy;
    logic              x_in, y_in;
    logic              chk_hit_reg, chk_wr_reg;
    logic [ADDR_W-1:0] chk_addr_reg;

    assign sq   = side_reg[ST_CHK-1];
    assign qx   = qx_reg[Q_BITS];
    assign qy   = qy_reg[Q_BITS];
    assign x_in = !ovx_reg[Q_BITS] && ((qx == '0) || okx_reg[Q_BITS])
                  && ({1'b0, qx} < sw);
    assign y_in = !ovy_reg[Q_BITS] && ((qy == '0) || oky_reg[Q_BITS])
                  && ({1'b0, qy} < sh);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            chk_hit_reg <= !sq.miss && !wzq_reg[Q_BITS] && x_in && y_in;
            chk_wr_reg  <= (sq.col < COORD_W'(MAX_SRC_W)) && (sq.row < COORD_W'(MAX_SRC_H));
            if (sq.cmd == CMD_MAP)
                chk_addr_reg <= {qy, qx};
            else
                chk_addr_reg <= {sq.row[SRC_H_BITS-1:0], sq.col[SRC_W_BITS-1:0]};
        end
    end

    // ------------------------------------------------------------------
    // Source store: write requests and map reads at the same stage
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] src_mem [MEM_DEPTH];
    logic [PIX_W-1:0] mem_rd_reg;
    side_t            sc;

    assign sc = side_reg[ST_CHK];

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[ST_CHK] && (sc.cmd == CMD_WRITE) && chk_wr_reg)
            src_mem[chk_addr_reg] <= sc.pix;
        if (adv)
            mem_rd_reg <= src_mem[chk_addr_reg];
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] out_col_reg, out_row_reg;
    logic               out_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= vld_reg[ST_CHK] && (sc.cmd == CMD_MAP);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_col_reg <= sc.col;
            out_row_reg <= sc.drow;
            out_hit_reg <= chk_hit_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign dest_col  = out_col_reg;
    assign dest_row  = out_row_reg;
    assign hit       = out_hit_reg;
    assign pixel_out = out_hit_reg ? mem_rd_reg : '0;

`ifndef ASSERT_OFF
    // A stall only arises behind a waiting result
    assert property (@(posedge clk) disable iff (!rst_n) in_stall |-> out_valid)
        else $error("pipeline stalled without a pending result");

    // A write request never produces a result
    assert property (@(posedge clk) disable iff (!rst_n)
        adv && vld_reg[ST_CHK] && (sc.cmd == CMD_WRITE) |=> !out_valid)
        else $error("write request produced a result");

    // A hit only comes from a column inside the output frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> ({1'b0, dest_col} < ow))
        else $error("hit reported for a column outside the output");
`endif

endmodule
